>>> rtl/ctsch_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Counter/priority task scheduler package
// Shared types and codes for the slot ring, the head update logic and the
// scheduler top level.
// ---------------------------------------------------------------------------
package ctsch_pkg;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_PREEMPT_DIS = 3'd1;
   localparam logic [2:0] OP_PREEMPT_EN  = 3'd2;
   localparam logic [2:0] OP_LOAD      = 3'd3;
   localparam logic [2:0] OP_SET_STATE = 3'd4;

   localparam int CNT_W   = 9;
   localparam int PRIO_W  = 8;
   localparam int DEPTH_W = 8;
   localparam int SLOT_W  = 6;

   typedef struct packed {
      logic               present;
      logic               running;
      logic [PRIO_W-1:0]  prio;
      logic [CNT_W-1:0]   counter;
      logic [DEPTH_W-1:0] depth;
   } slot_rec_type;

   typedef struct packed {
      logic         lap2;
      logic [2:0]   op;
      logic         is_cur;
      logic         is_slot;
      slot_rec_type load_rec;
   } head_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAP,
      ST_LAP2,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

>>> rtl/ctsch_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Slot ring cell
// Holds one task slot record and passes it to the next cell of the ring
// whenever the ring rotates.
// ---------------------------------------------------------------------------
module ctsch_cell #(
   parameter bit BOOT_SLOT = 1'b0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          shift,
   input  wire ctsch_pkg::slot_rec_type rec_in,
   output ctsch_pkg::slot_rec_type      rec_out
);

   ctsch_pkg::slot_rec_type rec_ff;
   ctsch_pkg::slot_rec_type rec_in_mux;

   always_comb begin
      rec_in_mux = shift ? rec_in : rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.present <= BOOT_SLOT;
         rec_ff.running <= BOOT_SLOT;
         rec_ff.prio    <= ctsch_pkg::PRIO_W'(BOOT_SLOT);
         rec_ff.counter <= '0;
         rec_ff.depth   <= '0;
      end else begin
         rec_ff <= rec_in_mux;
      end
   end

   assign rec_out = rec_ff;

endmodule
`default_nettype wire

>>> rtl/ctsch_head.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Ring head update
// Applies the pending event to the slot record that passes the head of the
// ring, and recomputes counters on the second lap of a reschedule.
// ---------------------------------------------------------------------------
module ctsch_head (
   input  wire ctsch_pkg::head_ctrl_type ctrl,
   input  wire ctsch_pkg::slot_rec_type  rec_in,
   output ctsch_pkg::slot_rec_type       rec_out,
   output logic                          trigger
);

   logic [ctsch_pkg::CNT_W-1:0] dec_cnt;

   always_comb begin
      rec_out = rec_in;
      trigger = 1'b0;
      dec_cnt = (rec_in.counter != '0) ? rec_in.counter - 1'b1 : rec_in.counter;
      if (ctrl.lap2) begin
         if (rec_in.present) begin
            rec_out.counter = ctsch_pkg::CNT_W'((rec_in.counter >> 1) +
                                                ctsch_pkg::CNT_W'(rec_in.prio));
         end
      end else begin
         case (ctrl.op)
            ctsch_pkg::OP_TICK: begin
               if (ctrl.is_cur) begin
                  rec_out.counter = dec_cnt;
                  trigger = (dec_cnt == '0) && (rec_in.depth == '0);
               end
            end
            ctsch_pkg::OP_PREEMPT_DIS: begin
               if (ctrl.is_cur && rec_in.depth != '1) begin
                  rec_out.depth = rec_in.depth + 1'b1;
               end
            end
            ctsch_pkg::OP_PREEMPT_EN: begin
               if (ctrl.is_cur && rec_in.depth != '0) begin
                  rec_out.depth = rec_in.depth - 1'b1;
               end
            end
            ctsch_pkg::OP_LOAD: begin
               if (ctrl.is_slot) begin
                  rec_out = ctrl.load_rec;
               end
            end
            ctsch_pkg::OP_SET_STATE: begin
               if (ctrl.is_slot) begin
                  rec_out.running = ctrl.load_rec.running;
               end
            end
            default: begin
               rec_out = rec_in;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/counter_priority_task_scheduler_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Counter/priority task scheduler
// Task slot table kept in a rotating ring of cells, with event handling and
// the largest-counter pick done at the head of the ring.
// ---------------------------------------------------------------------------
// The slot table lives in a ring of NUM_TASKS cells that rotates one slot per
// cycle during a lap past a single head update stage, so every event walks the
// whole ring at least once. An item is accepted in the idle state, walks the
// ring in the scan lap and has its result registered in the output state. A
// tick that finds every runnable counter at zero takes a second lap for the
// recompute. One item is in work at a time; a new item is accepted while the
// previous result still waits on rsp_stall, and its own result then waits
// until that one is taken.
module counter_priority_task_scheduler_core #(
   parameter int NUM_TASKS = 64
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [2:0] req_operation,
   input  wire  [5:0] req_slot,
   input  wire        req_present,
   input  wire        req_running,
   input  wire  [7:0] req_priority_req,
   input  wire  [8:0] req_initial_count,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [5:0] rsp_current_task,
   output logic       rsp_switched,
   output logic       rsp_stuck_no_slice
);

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CMP_W = (IDX_W > ctsch_pkg::SLOT_W) ? IDX_W : ctsch_pkg::SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

   ctsch_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] current_ff, current_in;
   logic [2:0] op_ff, op_in;
   logic [ctsch_pkg::SLOT_W-1:0] slot_ff, slot_in;
   ctsch_pkg::slot_rec_type load_rec_ff, load_rec_in;
   logic best_valid_ff, best_valid_in;
   logic [ctsch_pkg::CNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic trig_ff, trig_in;
   logic res_sw_ff, res_sw_in;
   logic res_stuck_ff, res_stuck_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [5:0] rsp_cur_ff, rsp_cur_in;
   logic rsp_sw_ff, rsp_sw_in;
   logic rsp_stuck_ff, rsp_stuck_in;

   logic shift;
   ctsch_pkg::head_ctrl_type head_ctrl;
   ctsch_pkg::slot_rec_type head_rec;
   logic head_trig;
   ctsch_pkg::slot_rec_type ring_q [NUM_TASKS];

   logic take;
   logic fin_valid;
   logic [ctsch_pkg::CNT_W-1:0] fin_cnt;
   logic [IDX_W-1:0] fin_idx;
   logic trig_seen;
   logic [IDX_W-1:0] next_task;
   logic [CMP_W-1:0] cur_ext;
   logic rsp_free;

   genvar g;
   generate
      for (g = 0; g < NUM_TASKS; g++) begin : g_ring
         if (g == 0) begin : g_first
            ctsch_cell #(.BOOT_SLOT(1'b1)) u_cell (
               .clock   (clock),
               .reset   (reset),
               .shift   (shift),
               .rec_in  (head_rec),
               .rec_out (ring_q[g])
            );
         end else begin : g_rest
            ctsch_cell #(.BOOT_SLOT(1'b0)) u_cell (
               .clock   (clock),
               .reset   (reset),
               .shift   (shift),
               .rec_in  (ring_q[g-1]),
               .rec_out (ring_q[g])
            );
         end
      end
   endgenerate

   always_comb begin
      head_ctrl.lap2     = (state_ff == ctsch_pkg::ST_LAP2);
      head_ctrl.op       = op_ff;
      head_ctrl.is_cur   = (idx_ff == current_ff);
      head_ctrl.is_slot  = (CMP_W'(idx_ff) == CMP_W'(slot_ff));
      head_ctrl.load_rec = load_rec_ff;
   end

   ctsch_head u_head (
      .ctrl    (head_ctrl),
      .rec_in  (ring_q[NUM_TASKS-1]),
      .rec_out (head_rec),
      .trigger (head_trig)
   );

   always_comb begin
      take = head_rec.present && head_rec.running &&
             (!best_valid_ff || head_rec.counter >= best_cnt_ff);
      fin_valid = best_valid_ff || take;
      fin_cnt   = take ? head_rec.counter : best_cnt_ff;
      fin_idx   = take ? idx_ff : best_idx_ff;
      trig_seen = trig_ff || head_trig;
      next_task = fin_valid ? fin_idx : '0;
      cur_ext   = CMP_W'(current_ff);
      rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      current_in    = current_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      load_rec_in   = load_rec_ff;
      best_valid_in = best_valid_ff;
      best_cnt_in   = best_cnt_ff;
      best_idx_in   = best_idx_ff;
      trig_in       = trig_ff;
      res_sw_in     = res_sw_ff;
      res_stuck_in  = res_stuck_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_cur_in    = rsp_cur_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_stuck_in  = rsp_stuck_ff;
      shift         = 1'b0;
      unique case (state_ff)
         ctsch_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in               = req_operation;
               slot_in             = req_slot;
               load_rec_in.present = req_present;
               load_rec_in.running = req_running;
               load_rec_in.prio    = req_priority_req;
               load_rec_in.counter = req_initial_count;
               load_rec_in.depth   = '0;
               idx_in              = LAST_IDX;
               best_valid_in       = 1'b0;
               trig_in             = 1'b0;
               state_in            = ctsch_pkg::ST_LAP;
            end
         end
         ctsch_pkg::ST_LAP, ctsch_pkg::ST_LAP2: begin
            shift         = 1'b1;
            idx_in        = idx_ff - 1'b1;
            best_valid_in = fin_valid;
            best_cnt_in   = fin_cnt;
            best_idx_in   = fin_idx;
            if (state_ff == ctsch_pkg::ST_LAP) begin
               trig_in = trig_seen;
            end
            if (idx_ff == '0) begin
               res_sw_in    = 1'b0;
               res_stuck_in = 1'b0;
               state_in     = ctsch_pkg::ST_OUT;
               if (state_ff == ctsch_pkg::ST_LAP) begin
                  if (op_ff == ctsch_pkg::OP_TICK && trig_seen) begin
                     if (fin_valid && fin_cnt == '0) begin
                        idx_in        = LAST_IDX;
                        best_valid_in = 1'b0;
                        state_in      = ctsch_pkg::ST_LAP2;
                     end else begin
                        current_in = next_task;
                        res_sw_in  = (next_task != current_ff);
                     end
                  end
               end else begin
                  if (fin_valid && fin_cnt == '0) begin
                     res_stuck_in = 1'b1;
                  end else begin
                     current_in = next_task;
                     res_sw_in  = (next_task != current_ff);
                  end
               end
            end
         end
         ctsch_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_cur_in   = cur_ext[5:0];
               rsp_sw_in    = res_sw_ff;
               rsp_stuck_in = res_stuck_ff;
               state_in     = ctsch_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctsch_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ctsch_pkg::ST_IDLE;
         current_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         trig_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         current_ff    <= current_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         best_valid_ff <= best_valid_in;
         trig_ff       <= trig_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      load_rec_ff  <= load_rec_in;
      best_cnt_ff  <= best_cnt_in;
      best_idx_ff  <= best_idx_in;
      res_sw_ff    <= res_sw_in;
      res_stuck_ff <= res_stuck_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_sw_ff    <= rsp_sw_in;
      rsp_stuck_ff <= rsp_stuck_in;
   end

   assign req_stall          = (state_ff != ctsch_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_task   = rsp_cur_ff;
   assign rsp_switched       = rsp_sw_ff;
   assign rsp_stuck_no_slice = rsp_stuck_ff;

   a_current_in_range: assert property (@(posedge clock) disable iff (reset)
      current_ff <= LAST_IDX)
      else $error("current task index beyond the slot table");

   a_stuck_not_switched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_switched && rsp_stuck_no_slice))
      else $error("result flags both a switch and a stuck recompute");

   a_lap2_follows_lap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctsch_pkg::ST_LAP2 |->
         ($past(state_ff) == ctsch_pkg::ST_LAP || $past(state_ff) == ctsch_pkg::ST_LAP2))
      else $error("recompute lap entered without a scan lap");

   a_current_stable_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctsch_pkg::ST_IDLE |=> $stable(current_ff))
      else $error("current task changed outside a scan lap");

endmodule
`default_nettype wire

>>> tb/counter_priority_task_scheduler_core_tb.sv
// ---------------------------------------------------------------------------
// Counter/priority task scheduler testbench
// Drives scheduler events over the valid/stall request channel and checks
// every returned pick against a cycle-free model of the slot table. Directed
// cases come first, then a long preempt depth run and random traffic under
// several idling mixes, including a long receiver hold-off.
// ---------------------------------------------------------------------------
module counter_priority_task_scheduler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TASKS      = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 2 * NUM_TASKS + 10;

   localparam logic [2:0] OP_RSVD5 = 3'd5;
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   typedef struct packed {
      logic [ctsch_pkg::SLOT_W-1:0] current_task;
      logic                         switched;
      logic                         stuck_no_slice;
   } pick_result_type;

   logic                          clock;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_stall;
   logic [2:0]                    req_operation     = ctsch_pkg::OP_TICK;
   logic [ctsch_pkg::SLOT_W-1:0]  req_slot          = '0;
   logic                          req_present       = 1'b0;
   logic                          req_running       = 1'b0;
   logic [ctsch_pkg::PRIO_W-1:0]  req_priority_req  = '0;
   logic [ctsch_pkg::CNT_W-1:0]   req_initial_count = '0;
   logic                          rsp_valid;
   logic                          rsp_stall         = 1'b0;
   logic [ctsch_pkg::SLOT_W-1:0]  rsp_current_task;
   logic                          rsp_switched;
   logic                          rsp_stuck_no_slice;

   logic                          task_present [NUM_TASKS];
   logic                          task_runnable[NUM_TASKS];
   logic [ctsch_pkg::PRIO_W-1:0]  task_prio    [NUM_TASKS];
   logic [ctsch_pkg::CNT_W-1:0]   task_slice   [NUM_TASKS];
   logic [ctsch_pkg::DEPTH_W-1:0] task_depth   [NUM_TASKS];
   int                            cur_task;

   pick_result_type     pending_picks[$];
   int                  error_count    = 0;
   int                  accepted_items = 0;
   int                  checked_picks  = 0;
   int                  stuck_seen     = 0;
   int                  switches_seen  = 0;
   int unsigned         send_idle_pct  = 0;
   int unsigned         stall_pct      = 0;
   bit                  hold_pending   = 1'b0;

   counter_priority_task_scheduler_core #(
      .NUM_TASKS(NUM_TASKS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_slot          (req_slot),
      .req_present       (req_present),
      .req_running       (req_running),
      .req_priority_req  (req_priority_req),
      .req_initial_count (req_initial_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_task  (rsp_current_task),
      .rsp_switched      (rsp_switched),
      .rsp_stuck_no_slice(rsp_stuck_no_slice)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void reset_slot_table();
      for (int i = 0; i < NUM_TASKS; i++) begin
         task_present[i]  = (i == 0);
         task_runnable[i] = (i == 0);
         task_prio[i]     = (i == 0) ? 8'd1 : 8'd0;
         task_slice[i]    = '0;
         task_depth[i]    = '0;
      end
      cur_task = 0;
   endfunction

   function automatic int pick_winner(output int best);
      int c;
      int win;
      c   = -1;
      win = 0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (task_present[i] && task_runnable[i] && int'(task_slice[i]) > c) begin
            c   = int'(task_slice[i]);
            win = i;
         end
      end
      best = c;
      return win;
   endfunction

   function automatic pick_result_type schedule_event(
      input logic [2:0]                   op,
      input logic [ctsch_pkg::SLOT_W-1:0] slot,
      input logic                         present,
      input logic                         running,
      input logic [ctsch_pkg::PRIO_W-1:0] prio,
      input logic [ctsch_pkg::CNT_W-1:0]  count
   );
      pick_result_type r;
      int              best;
      int              next;
      bit              keep;
      r.switched       = 1'b0;
      r.stuck_no_slice = 1'b0;
      case (op)
         ctsch_pkg::OP_TICK: begin
            if (task_slice[cur_task] != 0)
               task_slice[cur_task] = task_slice[cur_task] - 1'b1;
            if (task_slice[cur_task] == 0 && task_depth[cur_task] == 0) begin
               keep = 1'b0;
               next = pick_winner(best);
               if (best == 0) begin
                  for (int i = 0; i < NUM_TASKS; i++) begin
                     if (task_present[i])
                        task_slice[i] = (task_slice[i] >> 1) + task_prio[i];
                  end
                  next = pick_winner(best);
                  if (best == 0) begin
                     r.stuck_no_slice = 1'b1;
                     keep             = 1'b1;
                  end
               end
               if (!keep && next != cur_task) begin
                  cur_task   = next;
                  r.switched = 1'b1;
               end
            end
         end
         ctsch_pkg::OP_PREEMPT_DIS: begin
            if (task_depth[cur_task] != '1)
               task_depth[cur_task] = task_depth[cur_task] + 1'b1;
         end
         ctsch_pkg::OP_PREEMPT_EN: begin
            if (task_depth[cur_task] != 0)
               task_depth[cur_task] = task_depth[cur_task] - 1'b1;
         end
         ctsch_pkg::OP_LOAD: begin
            task_present[slot]  = present;
            task_runnable[slot] = running;
            task_prio[slot]     = prio;
            task_slice[slot]    = count;
            task_depth[slot]    = '0;
         end
         ctsch_pkg::OP_SET_STATE: begin
            task_runnable[slot] = running;
         end
         default: begin
         end
      endcase
      r.current_task = ctsch_pkg::SLOT_W'(cur_task);
      return r;
   endfunction

   function automatic void check_field(input string what, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      pick_result_type exp_pick;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_picks.size() == 0) begin
               $display("%0t: unexpected result, expected none, %s %0d switched %0d stuck %0d",
                        $time, "actual task", rsp_current_task, rsp_switched,
                        rsp_stuck_no_slice);
               error_count++;
            end else begin
               exp_pick = pending_picks.pop_front();
               check_field("current_task", exp_pick.current_task, rsp_current_task);
               check_field("switched", exp_pick.switched, rsp_switched);
               check_field("stuck_no_slice", exp_pick.stuck_no_slice, rsp_stuck_no_slice);
               checked_picks++;
               if (exp_pick.switched)
                  switches_seen++;
               if (exp_pick.stuck_no_slice)
                  stuck_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            pending_picks.push_back(schedule_event(req_operation, req_slot, req_present,
                                                   req_running, req_priority_req,
                                                   req_initial_count));
            accepted_items++;
         end
      end
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("%0t: watchdog expired after %0d cycles without a handshake",
               $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   task automatic send_item(
      input logic [2:0]                   op,
      input logic [ctsch_pkg::SLOT_W-1:0] slot,
      input logic                         present,
      input logic                         running,
      input logic [ctsch_pkg::PRIO_W-1:0] prio,
      input logic [ctsch_pkg::CNT_W-1:0]  count
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_slot          <= slot;
      req_present       <= present;
      req_running       <= running;
      req_priority_req  <= prio;
      req_initial_count <= count;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
   endtask

   task automatic reset_state_test();
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(OP_RSVD5, 6'd63, 1'b1, 1'b1, 8'd255, 9'd510);
      send_item(OP_RSVD6, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(OP_RSVD7, 6'd42, 1'b1, 1'b0, 8'd170, 9'd341);
      send_item(ctsch_pkg::OP_LOAD, 6'd63, 1'b1, 1'b1, 8'd255, 9'd510);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
   endtask

   task automatic preempt_test();
      send_item(ctsch_pkg::OP_LOAD, 6'd63, 1'b1, 1'b1, 8'd255, 9'd1);
      send_item(ctsch_pkg::OP_PREEMPT_DIS, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_PREEMPT_EN, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_PREEMPT_EN, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
   endtask

   task automatic tie_test();
      send_item(ctsch_pkg::OP_LOAD, 6'd9, 1'b1, 1'b1, 8'd2, 9'd7);
      send_item(ctsch_pkg::OP_LOAD, 6'd5, 1'b1, 1'b1, 8'd2, 9'd7);
      send_item(ctsch_pkg::OP_LOAD, 6'd63, 1'b1, 1'b1, 8'd255, 9'd1);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
   endtask

   task automatic stuck_test();
      send_item(ctsch_pkg::OP_LOAD, 6'd0, 1'b1, 1'b1, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_LOAD, 6'd9, 1'b0, 1'b1, 8'd4, 9'd3);
      send_item(ctsch_pkg::OP_LOAD, 6'd63, 1'b1, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_LOAD, 6'd5, 1'b1, 1'b1, 8'd0, 9'd1);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
   endtask

   task automatic no_runnable_test();
      send_item(ctsch_pkg::OP_SET_STATE, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_SET_STATE, 6'd5, 1'b1, 1'b0, 8'd255, 9'd510);
      send_item(ctsch_pkg::OP_SET_STATE, 6'd9, 1'b0, 1'b1, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
   endtask

   task automatic absent_current_test();
      send_item(ctsch_pkg::OP_LOAD, 6'd0, 1'b0, 1'b1, 8'd3, 9'd2);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
   endtask

   task automatic depth_saturation_test();
      send_item(ctsch_pkg::OP_LOAD, 6'd0, 1'b1, 1'b1, 8'd1, 9'd0);
      send_item(ctsch_pkg::OP_LOAD, 6'd1, 1'b1, 1'b1, 8'd1, 9'd9);
      repeat (256) send_item(ctsch_pkg::OP_PREEMPT_DIS, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      repeat (255) send_item(ctsch_pkg::OP_PREEMPT_EN, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
      send_item(ctsch_pkg::OP_PREEMPT_EN, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0);
   endtask

   task automatic send_random_item();
      int unsigned                  roll;
      logic [2:0]                   op;
      logic [ctsch_pkg::SLOT_W-1:0] slot;
      logic                         present;
      logic                         running;
      logic [ctsch_pkg::PRIO_W-1:0] prio;
      logic [ctsch_pkg::CNT_W-1:0]  count;
      roll    = $urandom_range(99);
      slot    = ($urandom_range(3) != 0) ? ctsch_pkg::SLOT_W'($urandom_range(7))
                                         : ctsch_pkg::SLOT_W'($urandom_range(63));
      present = ($urandom_range(9) != 0);
      running = ($urandom_range(3) != 0);
      prio    = ($urandom_range(4) != 0) ? ctsch_pkg::PRIO_W'($urandom_range(3))
                                         : ctsch_pkg::PRIO_W'($urandom_range(255));
      count   = ($urandom_range(5) != 0) ? ctsch_pkg::CNT_W'($urandom_range(6))
                                         : ctsch_pkg::CNT_W'($urandom_range(510));
      if (roll < 40)
         op = ctsch_pkg::OP_TICK;
      else if (roll < 50)
         op = ctsch_pkg::OP_PREEMPT_DIS;
      else if (roll < 62)
         op = ctsch_pkg::OP_PREEMPT_EN;
      else if (roll < 84)
         op = ctsch_pkg::OP_LOAD;
      else if (roll < 97)
         op = ctsch_pkg::OP_SET_STATE;
      else begin
         case ($urandom_range(2))
            0:       op = OP_RSVD5;
            1:       op = OP_RSVD6;
            default: op = OP_RSVD7;
         endcase
      end
      send_item(op, slot, present, running, prio, count);
   endtask

   task automatic random_phase_test(input int n, input int unsigned send_pct,
                                    input int unsigned recv_pct, input bit with_hold);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      for (int i = 0; i < n; i++) begin
         if (with_hold && i == n / 2)
            hold_pending = 1'b1;
         send_random_item();
      end
   endtask

   initial begin
      reset_slot_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      reset_state_test();
      preempt_test();
      tie_test();
      stuck_test();
      no_runnable_test();
      absent_current_test();
      depth_saturation_test();
      random_phase_test(150, 0, 0, 1'b1);
      random_phase_test(150, 79, 0, 1'b0);
      random_phase_test(150, 0, 79, 1'b0);
      random_phase_test(150, 29, 29, 1'b0);

      req_valid     <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      while (pending_picks.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d events (%0d results checked, %0d task switches, %0d stuck recomputes)",
               accepted_items, checked_picks, switches_seen, stuck_seen);
      $display("over directed picks, preempt depth limits and four idling mixes with a hold-off.");
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
